>>> hdl/wsc_pkg.sv
// Shared types, constants and helper functions for the synthesizer channel word block.
// No dependencies; imported by every module under hdl/.
package wsc_pkg;

  localparam int FREQ_W = 13;
  localparam int WORD_W = 30;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes
  localparam logic CFG_IDX_SYNTH_STYLE = 1'b0;
  localparam logic CFG_IDX_LATE_REV = 1'b1;

  localparam logic [FREQ_W-1:0] FREQ_BAND_SPLIT = 13'd4800;
  localparam logic [FREQ_W-1:0] FREQ_G20_LOW = 13'd5120;
  localparam logic [FREQ_W-1:0] FREQ_JAPAN = 13'd2484;
  localparam logic [FREQ_W-1:0] LEG_BASE_A = 13'd2192;  // f mod 5 == 2 grid origin
  localparam logic [FREQ_W-1:0] LEG_BASE_B = 13'd2224;  // f mod 5 == 4 grid origin

  // Reference select codes as they appear in the word
  localparam logic [1:0] REFSEL_NONE = 2'd0;
  localparam logic [1:0] REFSEL_REV1 = 2'd2;  // select 1, bit-reversed
  localparam logic [1:0] REFSEL_REV2 = 2'd1;  // select 2, bit-reversed
  localparam logic [1:0] REFSEL_10M = 2'd2;
  localparam logic [1:0] REFSEL_20M = 2'd3;

  // floor(2^16/15) and floor(2^15/15) parts of the fractional scaling
  localparam logic [12:0] FRAC_MUL_2G = 13'd4369;
  localparam logic [12:0] FRAC_MUL_5G = 13'd2184;
  // ceil(2^20/15): exact floor(y/15) for any 16-bit y
  localparam logic [16:0] RECIP15 = 17'd69906;
  // inverse of 5 modulo 1024
  localparam logic [7:0] INV5 = 8'd205;

  typedef struct packed {
    logic synth_style;
    logic late_revision;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] synth_word;
    logic              valid_res;
    logic              cck_update;
    logic              japan_filter;
    logic              refdiv_one;
  } res_t;

  // f mod 5 via hex digit sums (16 = 1 mod 5)
  function automatic logic [2:0] mod5_13(input logic [FREQ_W-1:0] v);
    logic [5:0] s1;
    logic [4:0] s2;
    logic [4:0] s3;
    s1 = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[12]);
    s2 = 5'(s1[5:4]) + 5'(s1[3:0]);
    s3 = (s2 >= 5'd15) ? s2 - 5'd15 : s2;
    if (s3 >= 5'd10) begin
      s3 = s3 - 5'd10;
    end else if (s3 >= 5'd5) begin
      s3 = s3 - 5'd5;
    end
    return s3[2:0];
  endfunction

  // Exact division by 5 modulo 1024; only valid where x is a multiple of 5
  function automatic logic [9:0] exact_div5(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'(INV5);
    return p[9:0];
  endfunction

  function automatic logic [12:0] div15(input logic [15:0] y);
    logic [32:0] p;
    p = 33'(y) * 33'(RECIP15);
    return p[32:20];
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

>>> hdl/wsc_cfg.sv
// Configuration register file: synthesizer style and chip revision select.
// Depends on wsc_pkg.
module wsc_cfg
  import wsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic cfg_wdata,
  output cfg_t cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_SYNTH_STYLE: cfg_nxt.synth_style = cfg_wdata;
        CFG_IDX_LATE_REV:    cfg_nxt.late_revision = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.synth_style <= 1'b0;
      cfg_r.late_revision <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/wsc_calc.sv
// Combinational channel word datapath: grid detection, exact /5 unit, fractional scaling.
// Depends on wsc_pkg.
module wsc_calc
  import wsc_pkg::*;
(
  input  logic [FREQ_W-1:0] freq_mhz,
  input  cfg_t              cfg,
  output res_t              res
);

  logic              lo_band;
  logic [2:0]        m5;
  logic              m5_zero;
  logic              g20;
  logic              g10;
  logic              l20;
  logic              l10;
  logic [FREQ_W-1:0] d;
  logic [FREQ_W-1:0] leg_base;
  logic [9:0]        x;
  logic [9:0]        q;
  logic [7:0]        chan_pre;
  logic [7:0]        chan8;
  logic              leg_valid;
  logic [1:0]        leg_refsel;
  logic              bmode;
  logic [WORD_W-1:0] leg_word;
  logic [25:0]       fmul;
  logic [15:0]       y;
  logic [12:0]       q15;
  logic [24:0]       chan_frac;
  logic [1:0]        frac_refsel;
  logic [WORD_W-1:0] frac_word;
  logic              is_japan;

  assign lo_band = freq_mhz < FREQ_BAND_SPLIT;
  assign m5 = mod5_13(freq_mhz);
  assign m5_zero = (m5 == 3'd0);
  assign g20 = m5_zero && (freq_mhz[1:0] == 2'b00);
  assign g10 = m5_zero && !freq_mhz[0];
  assign l20 = g20 && (freq_mhz >= FREQ_G20_LOW);
  assign l10 = !l20 && g10;
  assign d = freq_mhz - FREQ_BAND_SPLIT;
  assign bmode = (m5 == 3'd4);
  assign leg_base = bmode ? LEG_BASE_B : LEG_BASE_A;
  assign is_japan = (freq_mhz == FREQ_JAPAN);

  // One shared exact /5 for every grid index and the integer divider
  always_comb begin
    if (!cfg.synth_style) begin
      if (lo_band) begin
        x = freq_mhz[9:0] - leg_base[9:0];
      end else if (l20) begin
        x = d[11:2];
      end else if (l10) begin
        x = d[10:1];
      end else begin
        x = d[9:0];
      end
    end else if (g20) begin
      x = freq_mhz[11:2];
    end else begin
      x = freq_mhz[10:1];
    end
  end

  assign q = exact_div5(x);

  // Legacy word
  always_comb begin
    if (lo_band || l20) begin
      chan_pre = {q[5:0], 2'b00};
    end else if (l10) begin
      chan_pre = {q[6:0], 1'b0};
    end else begin
      chan_pre = q[7:0];
    end
    chan8 = rev8(chan_pre);

    if (lo_band) begin
      leg_valid = (m5 == 3'd2) || (m5 == 3'd4);
      leg_refsel = REFSEL_NONE;
    end else begin
      leg_valid = m5_zero;
      if (l10 && cfg.late_revision) begin
        leg_refsel = REFSEL_REV2;
      end else begin
        leg_refsel = REFSEL_REV1;
      end
    end

    if (leg_valid) begin
      leg_word = {14'd0, chan8, 2'b00, 1'b1, 1'b0, leg_refsel, bmode && lo_band, 1'b1};
    end else begin
      leg_word = '0;
    end
  end

  // Fractional word: f*2^16/15 = f*4369 + f/15, f*2^15/15 = f*2184 + 8f/15
  assign fmul = 26'(freq_mhz) * 26'(lo_band ? FRAC_MUL_2G : FRAC_MUL_5G);
  assign y = lo_band ? {3'b000, freq_mhz} : {freq_mhz, 3'b000};
  assign q15 = div15(y);
  assign chan_frac = fmul[24:0] + 25'(q15);

  always_comb begin
    if (g20) begin
      frac_refsel = REFSEL_20M;
    end else if (g10) begin
      frac_refsel = REFSEL_10M;
    end else begin
      frac_refsel = REFSEL_NONE;
    end

    if (lo_band) begin
      frac_word = {1'b1, 1'b1, REFSEL_NONE, 1'b0, chan_frac};
    end else if (frac_refsel == REFSEL_NONE) begin
      frac_word = {1'b0, 1'b1, REFSEL_NONE, 1'b0, chan_frac};
    end else begin
      frac_word = (WORD_W'(frac_refsel) << 26) | (WORD_W'(q[8:0]) << 17)
                | (WORD_W'(q[9]) << 10);
    end
  end

  always_comb begin
    if (!cfg.synth_style) begin
      res.synth_word = leg_word;
      res.valid_res = leg_valid;
      res.cck_update = lo_band && leg_valid;
      res.japan_filter = lo_band && leg_valid && is_japan;
      res.refdiv_one = 1'b0;
    end else begin
      res.synth_word = frac_word;
      res.valid_res = 1'b1;
      res.cck_update = lo_band;
      res.japan_filter = lo_band && is_japan;
      res.refdiv_one = !lo_band && !g10;
    end
  end

endmodule

>>> hdl/wifi_synth_channel_word.sv
// Top level of the synthesizer channel word block: input register, datapath, result register.
// Depends on wsc_pkg, wsc_cfg and wsc_calc.
//
// Usage:
//   in_*  : one transfer carries a centre frequency in MHz (in_tdata[12:0]).
//   out_* : one transfer per input with the 30-bit control word and flags.
//   cfg_* : write-only registers (0 synth style, 1 late revision), written while idle.
// out_tvalid rises once the item has passed the input register and then the result
// register; one item per cycle is sustained while the receiver keeps out_tready high,
// with a single pass through the datapath (one exact /5 multiplier and the fractional
// scaling multipliers between the two registers).
// The input register keeps accepting while a finished result waits in the
// output register; with both full and the receiver stalled, in_tready drops.
// Reset (rst_n low, synchronous) empties both stages and sets legacy style with
// late revision selected. Results are never dropped or repeated under stall.
module wifi_synth_channel_word
  import wsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_idx,
  input  logic                   cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [12:0] freq_mhz, [15:13] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [29:0] synth_word, [30] valid_res, [31] cck_update, [32] japan_filter,
  // [33] refdiv_one, [39:34] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t              cfg;
  res_t              res;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [FREQ_W-1:0] freq_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  res_t              res_r;
  logic              s2_en;

  wsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wsc_calc u_calc (
    .freq_mhz (freq_r),
    .cfg      (cfg),
    .res      (res)
  );

  assign s2_en = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_en;
  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = s2_en ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      freq_r <= in_tdata[FREQ_W-1:0];
    end
    if (s2_en && s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, res_r.refdiv_one, res_r.japan_filter, res_r.cck_update,
                      res_r.valid_res, res_r.synth_word};

  // An accepted transfer always lands in the input stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted input not held in input stage");

  // A pending input moves on once the result register frees up
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_en) |=> out_valid_r)
    else $error("input stage item lost on its way to the result register");

  // Rejected frequency carries an all-zero word and no CCK update
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.valid_res) |-> (res_r.synth_word == '0 && !res_r.cck_update))
    else $error("invalid frequency produced a word");

  // Japan bit only with a CCK update, and never alongside a forced divider
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!res_r.japan_filter || res_r.cck_update)
                     && !(res_r.refdiv_one && res_r.cck_update)))
    else $error("inconsistent result flags");

endmodule
